@@ rtl/isodata_threshold_top_defines.svh @@
// Assertion macros for the isodata threshold block.
// Used by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ISODATA_THRESHOLD_TOP_DEFINES_SVH
`define ISODATA_THRESHOLD_TOP_DEFINES_SVH

// Condition holds on every clock while out of reset.
`define ISO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies the consequent on the next clock.
`define ISO_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/iso_pkg.sv @@
// Shared types, widths and command codes of the isodata threshold block.
// No dependencies.
package iso_pkg;

  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int MAX_ROUNDS      = 64;
  localparam int PIX_W   = 8;
  localparam int BINS    = 1 << PIX_W;
  localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
  localparam int TOT_W   = MAX_PIXELS_LOG2 + PIX_W;
  localparam int NUM_W   = TOT_W + CNT_W + 1;
  localparam int DEN_W   = 2 * CNT_W + 1;
  localparam int DIV_W   = DEN_W + PIX_W;
  localparam int QB_W    = $clog2(PIX_W);
  localparam int RND_W   = $clog2(MAX_ROUNDS + 1);
  localparam int STS_W   = 2;

  localparam logic [STS_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STS_W-1:0] ST_LIMIT     = 2'd2;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_ACC_RD  = 4'd1;
  localparam logic [3:0] OP_ACC_WR  = 4'd2;
  localparam logic [3:0] OP_CLR     = 4'd3;
  localparam logic [3:0] OP_MEAN_LD = 4'd4;
  localparam logic [3:0] OP_DIV     = 4'd5;
  localparam logic [3:0] OP_SET_T   = 4'd6;
  localparam logic [3:0] OP_SWP_INI = 4'd7;
  localparam logic [3:0] OP_SWEEP   = 4'd8;
  localparam logic [3:0] OP_MUL1    = 4'd9;
  localparam logic [3:0] OP_MUL2    = 4'd10;
  localparam logic [3:0] OP_SUM     = 4'd11;
  localparam logic [3:0] OP_OUT_LD  = 4'd12;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] threshold;
    logic [STS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [STS_W-1:0] out_status;
  } iso_cmd_t;

  typedef struct packed {
    logic sweep_end;
    logic class_empty;
    logic div_last;
    logic q_eq_t;
    logic out_full;
  } iso_sts_t;

endpackage

@@ rtl/iso_datapath.sv @@
// Datapath: histogram memory, accumulators, multipliers, serial divider, output register.
// Depends on iso_pkg.
module iso_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  iso_pkg::iso_cmd_t  cmd,
  input  iso_pkg::in_item_t  in_data,
  output iso_pkg::iso_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output iso_pkg::out_item_t out_data
);
  import iso_pkg::*;

  logic [CNT_W-1:0] mem [BINS];
  logic [CNT_W-1:0] rd_data_r;
  logic [PIX_W-1:0] raddr;
  logic [PIX_W-1:0] pix_r;
  logic             ok_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TOT_W-1:0] tot_r;
  logic [PIX_W-1:0] idx_r;
  logic [PIX_W-1:0] rdidx_r;
  logic             rdv_r;
  logic [CNT_W-1:0] no_r, nb_r;
  logic [TOT_W-1:0] so_r, sb_r;
  logic [NUM_W-2:0] p1_r, p2_r;
  logic [DEN_W-2:0] d_r;
  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [PIX_W-1:0] q_r;
  logic [QB_W-1:0]  bit_r;
  logic [PIX_W-1:0] t_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [DIV_W-1:0] shd;
  logic [DIV_W-1:0] remx;
  logic [TOT_W-1:0] cv;

  assign raddr = (cmd.op == OP_ACC_RD) ? in_data.pixel : idx_r;
  assign shd   = DIV_W'(den_r) << bit_r;
  assign remx  = DIV_W'(rem_r);
  assign cv    = TOT_W'(rd_data_r * rdidx_r);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
    if (cmd.op == OP_ACC_WR && ok_r) begin
      mem[pix_r] <= rd_data_r + 1'b1;
    end else if (cmd.op == OP_CLR) begin
      mem[idx_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      cnt_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
    end else begin
      rdv_r <= (cmd.op == OP_SWEEP);
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ACC_RD: begin
          pix_r <= in_data.pixel;
          ok_r  <= (cnt_r < CNT_W'(1 << MAX_PIXELS_LOG2));
        end
        OP_ACC_WR: begin
          if (ok_r) begin
            cnt_r <= cnt_r + 1'b1;
            tot_r <= tot_r + TOT_W'(pix_r);
          end
        end
        OP_CLR: begin
          idx_r <= idx_r + 1'b1;
          cnt_r <= '0;
          tot_r <= '0;
        end
        OP_MEAN_LD: begin
          rem_r <= NUM_W'(tot_r);
          den_r <= DEN_W'(cnt_r);
          q_r   <= '0;
          bit_r <= QB_W'(PIX_W - 1);
        end
        OP_DIV: begin
          if (remx >= shd) begin
            rem_r      <= NUM_W'(remx - shd);
            q_r[bit_r] <= 1'b1;
          end
          bit_r <= bit_r - 1'b1;
        end
        OP_SET_T: t_r <= q_r;
        OP_SWP_INI: begin
          no_r <= '0;
          nb_r <= '0;
          so_r <= '0;
          sb_r <= '0;
        end
        OP_SWEEP: begin
          rdidx_r <= idx_r;
          idx_r   <= idx_r + 1'b1;
        end
        OP_MUL1: begin
          p1_r <= so_r * nb_r;
          d_r  <= no_r * nb_r;
        end
        OP_MUL2: p2_r <= sb_r * no_r;
        OP_SUM: begin
          rem_r <= NUM_W'(p1_r) + NUM_W'(p2_r);
          den_r <= {d_r, 1'b0};
          q_r   <= '0;
          bit_r <= QB_W'(PIX_W - 1);
        end
        OP_OUT_LD: begin
          out_valid_r          <= 1'b1;
          out_data_r.threshold <= t_r;
          out_data_r.status    <= cmd.out_status;
        end
        default: ;
      endcase
      if (rdv_r) begin
        if (rdidx_r >= t_r) begin
          no_r <= no_r + rd_data_r;
          so_r <= so_r + cv;
        end else begin
          nb_r <= nb_r + rd_data_r;
          sb_r <= sb_r + cv;
        end
      end
    end
  end

  assign sts.sweep_end   = (idx_r == PIX_W'(BINS - 1));
  assign sts.class_empty = (no_r == '0) || (nb_r == '0);
  assign sts.div_last    = (bit_r == '0);
  assign sts.q_eq_t      = (q_r == t_r);
  assign sts.out_full    = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

@@ rtl/iso_ctrl.sv @@
// Controller: sequences accumulation, mean, threshold rounds, result and clear pass.
// Depends on iso_pkg and isodata_threshold_top_defines.svh.
`include "isodata_threshold_top_defines.svh"
module iso_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  iso_pkg::iso_sts_t sts,
  output iso_pkg::iso_cmd_t cmd
);
  import iso_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ACC_WR = 4'd2;
  localparam logic [3:0] S_MEANLD = 4'd3;
  localparam logic [3:0] S_MDIV   = 4'd4;
  localparam logic [3:0] S_SET_T  = 4'd5;
  localparam logic [3:0] S_RCHK   = 4'd6;
  localparam logic [3:0] S_SWEEP  = 4'd7;
  localparam logic [3:0] S_SWFIN  = 4'd8;
  localparam logic [3:0] S_ECHK   = 4'd9;
  localparam logic [3:0] S_MUL2   = 4'd10;
  localparam logic [3:0] S_SUM    = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_CMP    = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic             last_r, last_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic [STS_W-1:0] res_r, res_nxt;
  logic             in_fire;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    round_nxt      = round_r;
    res_nxt        = res_r;
    cmd.op         = OP_NONE;
    cmd.out_status = res_r;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (sts.sweep_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACC_RD;
          last_nxt  = in_last;
          state_nxt = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        cmd.op    = OP_ACC_WR;
        state_nxt = last_r ? S_MEANLD : S_IDLE;
      end
      S_MEANLD: begin
        cmd.op    = OP_MEAN_LD;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) state_nxt = S_SET_T;
      end
      S_SET_T: begin
        cmd.op    = OP_SET_T;
        round_nxt = '0;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (round_r == RND_W'(MAX_ROUNDS)) begin
          res_nxt   = ST_LIMIT;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_SWP_INI;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (sts.sweep_end) state_nxt = S_SWFIN;
      end
      S_SWFIN: state_nxt = S_ECHK;
      S_ECHK: begin
        if (sts.class_empty) begin
          res_nxt   = ST_EMPTY;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_MUL1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.q_eq_t) begin
          res_nxt   = ST_CONVERGED;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_SET_T;
          round_nxt = round_r + 1'b1;
          state_nxt = S_RCHK;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.op    = OP_OUT_LD;
          state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      last_r  <= 1'b0;
      round_r <= '0;
      res_r   <= ST_CONVERGED;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      round_r <= round_nxt;
      res_r   <= res_nxt;
    end
  end

  `ISO_ASSERT_NEXT(a_fire_to_wr, in_fire, state_r == S_ACC_WR, "request not written back")
  `ISO_ASSERT_ALWAYS(a_round_cap, round_r <= RND_W'(MAX_ROUNDS), "round counter overrun")
  `ISO_ASSERT_ALWAYS(a_out_free, (cmd.op != OP_OUT_LD) || !sts.out_full, "result overwritten")

endmodule

@@ rtl/isodata_threshold_top.sv @@
// Each pixel is read from the histogram, then written back before the next pixel is taken;
// at frame end, a mean division, then per round a histogram sweep, three multiplies in two
// steps and an 8-step divider, up to 64 rounds. After each result a histogram clear pass
// runs; no pixel is taken then. Reset (rst_n low, synchronous) starts the same clear pass.
// Throughput is set by the histogram read-modify-write and sweeps.
module isodata_threshold_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iso_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iso_pkg::out_item_t out_data
);
  import iso_pkg::*;

  iso_cmd_t cmd;
  iso_sts_t sts;

  iso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iso_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb.sv @@
// Testbench for isodata_threshold_top: random and directed frames, self-checking.
// Predicts the ISODATA threshold per frame and compares each result in order.
// Depends on iso_pkg and the isodata_threshold_top RTL.
`timescale 1ns / 100ps

module tb;
  import iso_pkg::*;

  localparam longint PIX_CAP     = 64'd1 << MAX_PIXELS_LOG2;
  localparam int     CYCLE_LIMIT = 100000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  isodata_threshold_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  in_item_t  pixel_queue[$];
  out_item_t thresh_expected[$];
  longint    hist[256];
  longint    pix_count;
  longint    pix_total;
  int        errors = 0;
  int        frames_done = 0;
  int        results_seen = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_on = 1'b0;
  bit        in_acc = 1'b0;
  int        cycle_count = 0;
  int        status_seen[3] = '{0, 0, 0};

  function automatic out_item_t predict_threshold();
    out_item_t res;
    longint no, so, nb, sb, t, nx;
    logic [STS_W-1:0] st;
    st = ST_LIMIT;
    t = pix_total / pix_count;
    nx = 0;
    for (int r = 0; r < MAX_ROUNDS; r++) begin
      no = 0; so = 0; nb = 0; sb = 0;
      for (int v = 0; v < 256; v++) begin
        if (v >= t) begin
          no += hist[v]; so += hist[v] * v;
        end else begin
          nb += hist[v]; sb += hist[v] * v;
        end
      end
      if (no == 0 || nb == 0) begin
        st = ST_EMPTY;
        break;
      end
      nx = (so * nb + sb * no) / (2 * no * nb);
      if (nx == t) begin
        st = ST_CONVERGED;
        break;
      end
      t = nx;
    end
    res.threshold = t[PIX_W-1:0];
    res.status = st;
    return res;
  endfunction

  task automatic accept_pixel(input in_item_t it);
    if (pix_count < PIX_CAP) begin
      hist[it.pixel]++;
      pix_count++;
      pix_total += it.pixel;
    end
    if (it.last) begin
      thresh_expected.push_back(predict_threshold());
      foreach (hist[i]) hist[i] = 0;
      pix_count = 0;
      pix_total = 0;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_acc = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) accept_pixel(in_data);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (thresh_expected.size() == 0) begin
          $error("unexpected result threshold=%0d status=%0d",
                 out_data.threshold, out_data.status);
          errors++;
        end else begin
          out_item_t e;
          e = thresh_expected.pop_front();
          if (e.status <= ST_LIMIT) status_seen[e.status]++;
          if (out_data.threshold !== e.threshold) begin
            $error("threshold expected %0d actual %0d", e.threshold, out_data.threshold);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_frame(input int n, input int lo, input int hi);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.pixel = PIX_W'($urandom_range(hi, lo));
      it.last  = (i == n - 1);
      pixel_queue.push_back(it);
    end
    frames_done++;
  endtask

  task automatic add_pixel(input int p, input bit l);
    in_item_t it;
    it.pixel = PIX_W'(p);
    it.last = l;
    pixel_queue.push_back(it);
    if (l) frames_done++;
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
  endtask

  task automatic random_frames(input int items);
    int sent, n, lo, hi, a, b;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
      case ($urandom_range(3))
        0: begin lo = 0; hi = 255; end
        1: begin
          a = $urandom_range(255); b = $urandom_range(255);
          lo = (a < b) ? a : b; hi = (a < b) ? b : a;
        end
        2: begin lo = $urandom_range(255); hi = lo; end
        default: begin lo = 0; hi = 255; end
      endcase
      if ($urandom_range(3) == 3) begin
        for (int i = 0; i < n; i++)
          add_pixel($urandom_range(1) ? $urandom_range(40) : $urandom_range(255, 215),
                    i == n - 1);
      end else begin
        add_frame(n, lo, hi);
      end
      sent += n;
      wait_drained();
    end
  endtask

  initial begin
    foreach (hist[i]) hist[i] = 0;
    pix_count = 0;
    pix_total = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: single pixels at extremes, a flat frame, two-level frames, spread multi-level frames
    add_pixel(0, 1'b1);
    add_pixel(255, 1'b1);
    add_pixel(0, 1'b0); add_pixel(255, 1'b1);
    add_pixel(7, 1'b0); add_pixel(7, 1'b0); add_pixel(7, 1'b1);
    add_pixel(0, 1'b0); add_pixel(0, 1'b0); add_pixel(1, 1'b1);
    add_pixel(254, 1'b0); add_pixel(255, 1'b1);
    add_pixel(10, 1'b0); add_pixel(20, 1'b0); add_pixel(200, 1'b0);
    add_pixel(240, 1'b0); add_pixel(128, 1'b1);
    add_pixel(85, 1'b0); add_pixel(170, 1'b0); add_pixel(1, 1'b0);
    add_pixel(2, 1'b0); add_pixel(4, 1'b0); add_pixel(8, 1'b0);
    add_pixel(16, 1'b1);
    wait_drained();

    send_idle_pct = 12; recv_idle_pct = 76;
    random_frames(360);

    // long receiver hold while frames keep coming
    fork
      begin
        hold_on = 1'b1;
        repeat (4000) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    add_frame(30, 0, 255);
    add_frame(30, 0, 255);
    add_frame(30, 50, 60);
    wait_drained();

    send_idle_pct = 76; recv_idle_pct = 12;
    random_frames(360);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_frames(360);

    while (thresh_expected.size() > 0) @(posedge clk);
    repeat (20000) @(posedge clk);

    $display("%0d frames sent, %0d results checked (converged %0d, empty %0d, limit %0d)",
             frames_done, results_seen, status_seen[0], status_seen[1], status_seen[2]);
    $display("idle mixes covered, long output hold with input backpressure exercised");
    if (errors == 0 && thresh_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
